// ----- design/c3cf_pkg.sv -----
// Shared types and constants of the 3x3 clamped convolution filter.
`default_nettype none

package c3cf_pkg;

    localparam int PIX_W      = 8;
    localparam int FW_W       = 11;
    localparam int FH_W       = 16;
    localparam int ROW_W      = 17;
    localparam int WT_W       = 16;
    localparam int WREG_W     = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int PROD_W     = 25;
    localparam int PSUM_W     = 27;
    localparam int SUM_W      = 29;
    localparam int OUT_DEPTH  = 8;
    localparam int OUT_PTR_W  = 3;
    localparam int OUT_CNT_W  = 4;

    typedef logic [PIX_W-1:0] pixel_t;
    typedef logic [2:0][PIX_W-1:0] pcol_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [PSUM_W-1:0] psum_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    localparam pixel_t PIX_MAX = 8'd255;
    localparam logic [FW_W-1:0] FW_RESET = 11'd1024;
    localparam logic [FH_W-1:0] FH_RESET = 16'd1;
    localparam logic [WREG_W-1:0] WREG_RESET_SIDE = 48'd0;
    localparam logic [WREG_W-1:0] WREG_RESET_CENTER = 48'd67108864;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH    = 3'd0,
        REG_FRAME_HEIGHT   = 3'd1,
        REG_WEIGHTS_FIRST  = 3'd2,
        REG_WEIGHTS_MIDDLE = 3'd3,
        REG_WEIGHTS_LAST   = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_DRAIN = 1'b1
    } cmd_t;

    typedef struct packed {
        logic left;
        logic right;
        logic top;
        logic bottom;
    } border_t;

    typedef struct packed {
        pixel_t pixel;
        logic   frame_end;
    } result_t;

endpackage

`default_nettype wire

// ----- design/c3cf_if.sv -----
// Stream channel interfaces for pixel input and filtered output items.
`default_nettype none

interface c3cf_in_if;
    logic                    valid;
    logic                    ready;
    logic                    cmd;
    logic [c3cf_pkg::PIX_W-1:0] pixel_in;

    modport source (output valid, output cmd, output pixel_in, input ready);
    modport sink   (input valid, input cmd, input pixel_in, output ready);
endinterface

interface c3cf_out_if;
    logic                    valid;
    logic                    ready;
    logic [c3cf_pkg::PIX_W-1:0] pixel_out;
    logic                    frame_end;

    modport source (output valid, output pixel_out, output frame_end, input ready);
    modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

`default_nettype wire

// ----- design/conv3x3_clamped_filter.sv -----
// 3x3 clamped convolution filter: line memory, window, multiply pipeline, output queue.
// Throughput: one item per cycle while pixels.ready is high; ready drops once the output
// queue and the pipeline stages together hold OUT_DEPTH items. The line memory is read
// and written back once per item; in items, results trail the input by frame_width+1.
// Reset: position, window, weights and geometry return to defaults at once;
// the line memory is not cleared and needs no clearing pass.
`default_nettype none

module conv3x3_clamped_filter #(
    parameter int MAX_WIDTH        = 1024,
    parameter int WEIGHT_FRAC_BITS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [c3cf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [c3cf_pkg::CFG_DATA_W-1:0]     cfg_data,
    c3cf_in_if.sink                             pixels,
    c3cf_out_if.source                          filtered
);

    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int PW  = WW + 1;
    localparam int OW  = WW + c3cf_pkg::FH_W;
    localparam int OCW = OW + 1;
    localparam int MW  = 2 * c3cf_pkg::PIX_W;

    // configuration
    logic [c3cf_pkg::FW_W-1:0]             frame_width_reg;
    logic [c3cf_pkg::FH_W-1:0]             frame_height_reg;
    logic [2:0][c3cf_pkg::WREG_W-1:0]      weights_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= c3cf_pkg::FW_RESET;
            frame_height_reg <= c3cf_pkg::FH_RESET;
            weights_reg[0]   <= c3cf_pkg::WREG_RESET_SIDE;
            weights_reg[1]   <= c3cf_pkg::WREG_RESET_CENTER;
            weights_reg[2]   <= c3cf_pkg::WREG_RESET_SIDE;
        end
        else if (cfg_write)
        begin
            unique case (c3cf_pkg::cfg_reg_t'(cfg_index))
                c3cf_pkg::REG_FRAME_WIDTH:
                    frame_width_reg <= cfg_data[c3cf_pkg::FW_W-1:0];
                c3cf_pkg::REG_FRAME_HEIGHT:
                    frame_height_reg <= cfg_data[c3cf_pkg::FH_W-1:0];
                c3cf_pkg::REG_WEIGHTS_FIRST:
                    weights_reg[0] <= cfg_data[c3cf_pkg::WREG_W-1:0];
                c3cf_pkg::REG_WEIGHTS_MIDDLE:
                    weights_reg[1] <= cfg_data[c3cf_pkg::WREG_W-1:0];
                c3cf_pkg::REG_WEIGHTS_LAST:
                    weights_reg[2] <= cfg_data[c3cf_pkg::WREG_W-1:0];
                default:
                    ;
            endcase
        end
    end

    logic [WW-1:0]                 w_eff;
    logic [c3cf_pkg::FH_W-1:0]     h_eff;
    logic [OW-1:0]                 total_px;

    always_comb
    begin
        if (frame_width_reg == '0)
            w_eff = WW'(1);
        else if (32'(frame_width_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(frame_width_reg);
        h_eff    = (frame_height_reg == '0) ? c3cf_pkg::FH_W'(1) : frame_height_reg;
        total_px = OW'(w_eff) * OW'(h_eff);
    end

    // input position
    logic [CW-1:0]              col_reg, col_next;
    logic [c3cf_pkg::ROW_W-1:0] row_reg, row_next;
    logic [OW-1:0]              count_reg, count_next;

    logic                       accept;
    logic                       is_drain;
    logic                       at_col0;
    logic                       skip;
    logic                       enter;
    logic                       emit;
    logic                       wrap;
    logic                       last;
    c3cf_pkg::pixel_t           px;
    c3cf_pkg::border_t          border;
    logic [PW-1:0]              col_p;
    logic [PW-1:0]              w_p;

    logic [c3cf_pkg::OUT_CNT_W-1:0] inflight;
    logic [c3cf_pkg::OUT_CNT_W-1:0] cnt_reg, cnt_next;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;

    assign accept   = pixels.valid && pixels.ready;
    assign is_drain = (pixels.cmd == c3cf_pkg::CMD_DRAIN);
    assign px       = is_drain ? '0 : pixels.pixel_in;
    assign at_col0  = (col_reg == '0);
    assign skip     = is_drain && at_col0 && (row_reg == '0);
    assign enter    = accept && !skip;
    assign col_p    = PW'(col_reg);
    assign w_p      = PW'(w_eff);
    assign emit     = (row_reg >= c3cf_pkg::ROW_W'(2))
                   || ((row_reg == c3cf_pkg::ROW_W'(1)) && !at_col0);
    assign wrap     = (col_p + PW'(1)) >= w_p;
    assign last     = (OCW'(count_reg) + OCW'(1)) >= OCW'(total_px);

    always_comb
    begin
        border.left   = at_col0 ? (w_eff != WW'(1)) : (col_reg != CW'(1));
        border.right  = !at_col0 && (col_p < w_p);
        border.top    = at_col0 ? (row_reg != c3cf_pkg::ROW_W'(2))
                                : (row_reg != c3cf_pkg::ROW_W'(1));
        border.bottom = at_col0
            ? ((row_reg - c3cf_pkg::ROW_W'(1)) < c3cf_pkg::ROW_W'(h_eff))
            : (row_reg < c3cf_pkg::ROW_W'(h_eff));
    end

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        count_next = count_reg;
        if (enter)
        begin
            if (emit && last)
            begin
                col_next   = '0;
                row_next   = '0;
                count_next = '0;
            end
            else
            begin
                if (wrap)
                begin
                    col_next = '0;
                    row_next = row_reg + c3cf_pkg::ROW_W'(1);
                end
                else
                begin
                    col_next = col_reg + CW'(1);
                end
                if (emit)
                    count_next = count_reg + OW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            count_reg <= count_next;
        end
    end

    // line memory: {row two up, row one up} per column
    logic [MW-1:0]   line_mem [MAX_WIDTH];
    logic [MW-1:0]   rd_reg;
    logic [MW-1:0]   wr_data;
    logic [CW-1:0]   s1_col_reg;
    c3cf_pkg::pixel_t s1_px_reg;

    assign wr_data = {rd_reg[c3cf_pkg::PIX_W-1:0], s1_px_reg};

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            line_mem[s1_col_reg] <= wr_data;
        if (enter)
        begin
            if (s1_valid_reg && (s1_col_reg == col_reg))
                rd_reg <= wr_data;
            else
                rd_reg <= line_mem[col_reg];
        end
    end

    // stage 1: window update and view selection
    logic              s1_emit_reg, s1_col0_reg, s1_last_reg;
    c3cf_pkg::border_t s1_border_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= enter;
    end

    always_ff @(posedge clk)
    begin
        if (enter)
        begin
            s1_col_reg    <= col_reg;
            s1_px_reg     <= px;
            s1_emit_reg   <= emit;
            s1_col0_reg   <= at_col0;
            s1_last_reg   <= emit && last;
            s1_border_reg <= border;
        end
    end

    c3cf_pkg::pcol_t win1_reg, win2_reg;
    c3cf_pkg::pcol_t new_col;
    c3cf_pkg::pcol_t view [3];
    c3cf_pkg::pcol_t view_masked [3];

    always_comb
    begin
        new_col[0] = rd_reg[MW-1:c3cf_pkg::PIX_W];
        new_col[1] = rd_reg[c3cf_pkg::PIX_W-1:0];
        new_col[2] = s1_px_reg;
        view[0]    = win1_reg;
        view[1]    = win2_reg;
        view[2]    = s1_col0_reg ? '0 : new_col;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if ((i == 0 && !s1_border_reg.left) || (i == 2 && !s1_border_reg.right)
                    || (j == 0 && !s1_border_reg.top) || (j == 2 && !s1_border_reg.bottom))
                    view_masked[i][j] = '0;
                else
                    view_masked[i][j] = view[i][j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win1_reg <= '0;
            win2_reg <= '0;
        end
        else if (s1_valid_reg)
        begin
            win1_reg <= win2_reg;
            win2_reg <= new_col;
        end
    end

    // stage 2: masked view
    c3cf_pkg::pcol_t s2_view_reg [3];
    logic            s2_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_view_reg <= view_masked;
        s2_last_reg <= s1_last_reg;
    end

    // stage 3: nine products
    c3cf_pkg::prod_t prod_next [3][3];
    c3cf_pkg::prod_t prod_reg [3][3];
    logic            s3_last_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod_next[i][j] = $signed({1'b0, s2_view_reg[i][j]})
                                * $signed(weights_reg[i][c3cf_pkg::WT_W*j +: c3cf_pkg::WT_W]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        prod_reg    <= prod_next;
        s3_last_reg <= s2_last_reg;
    end

    // stage 4: column partial sums
    c3cf_pkg::psum_t psum_next [3];
    c3cf_pkg::psum_t psum_reg [3];
    logic            s4_last_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            psum_next[i] = c3cf_pkg::psum_t'(prod_reg[i][0])
                         + c3cf_pkg::psum_t'(prod_reg[i][1])
                         + c3cf_pkg::psum_t'(prod_reg[i][2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        psum_reg    <= psum_next;
        s4_last_reg <= s3_last_reg;
    end

    // final sum, truncate, clamp
    c3cf_pkg::sum_t           total;
    logic [c3cf_pkg::SUM_W-1:0] mag;
    c3cf_pkg::result_t        result;

    always_comb
    begin
        total = c3cf_pkg::sum_t'(psum_reg[0]) + c3cf_pkg::sum_t'(psum_reg[1])
              + c3cf_pkg::sum_t'(psum_reg[2]);
        mag   = unsigned'(total) >> WEIGHT_FRAC_BITS;
        if (total <= 0)
            result.pixel = '0;
        else if (mag > c3cf_pkg::SUM_W'(c3cf_pkg::PIX_MAX))
            result.pixel = c3cf_pkg::PIX_MAX;
        else
            result.pixel = mag[c3cf_pkg::PIX_W-1:0];
        result.frame_end = s4_last_reg;
    end

    // output queue
    c3cf_pkg::result_t             fifo_mem [c3cf_pkg::OUT_DEPTH];
    logic [c3cf_pkg::OUT_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic                          push, pop;

    assign push = s4_valid_reg;
    assign pop  = filtered.valid && filtered.ready;

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem[wr_ptr_reg] <= result;
    end

    assign cnt_next = cnt_reg + c3cf_pkg::OUT_CNT_W'(push) - c3cf_pkg::OUT_CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + c3cf_pkg::OUT_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + c3cf_pkg::OUT_PTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

    assign inflight = cnt_reg
                    + c3cf_pkg::OUT_CNT_W'(s1_valid_reg) + c3cf_pkg::OUT_CNT_W'(s2_valid_reg)
                    + c3cf_pkg::OUT_CNT_W'(s3_valid_reg) + c3cf_pkg::OUT_CNT_W'(s4_valid_reg);

    assign pixels.ready       = inflight < c3cf_pkg::OUT_CNT_W'(c3cf_pkg::OUT_DEPTH);
    assign filtered.valid     = (cnt_reg != '0);
    assign filtered.pixel_out = fifo_mem[rd_ptr_reg].pixel;
    assign filtered.frame_end = fifo_mem[rd_ptr_reg].frame_end;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= c3cf_pkg::OUT_CNT_W'(c3cf_pkg::OUT_DEPTH))
        else $error("output queue overflow");

    a_stage2_source: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> $past(s1_valid_reg && s1_emit_reg))
        else $error("stage 2 item without an emitting stage 1 item");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (enter && emit && last) |=> (col_reg == '0 && row_reg == '0 && count_reg == '0))
        else $error("position not cleared after frame end");

    a_idle_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && skip) |=> !s1_valid_reg)
        else $error("idle drain item entered the pipeline");

endmodule

`default_nettype wire

// ----- verif/tb_conv3x3_clamped_filter.sv -----
// Self-checking 3x3 clamped filter testbench: edge cases, then random frames under stalls.
`timescale 1ns / 1ps

module tb_conv3x3_clamped_filter;

    localparam int LINE_LEN     = 1024;
    localparam int FRAC_BITS    = 10;
    localparam int SETTLE       = 10;
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 700;

    typedef struct packed {
        c3cf_pkg::cmd_t   kind;
        c3cf_pkg::pixel_t value;
    } pix_item_t;

    logic                            clk        = 1'b0;
    logic                            rst_n      = 1'b0;
    logic                            cfg_write  = 1'b0;
    logic [c3cf_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [c3cf_pkg::CFG_DATA_W-1:0] cfg_data   = '0;
    logic                            send_valid = 1'b0;
    c3cf_pkg::cmd_t                  send_cmd   = c3cf_pkg::CMD_PIXEL;
    c3cf_pkg::pixel_t                send_pixel = '0;
    logic                            take_ready = 1'b0;

    logic [c3cf_pkg::FW_W-1:0]   geo_width;
    logic [c3cf_pkg::FH_W-1:0]   geo_height;
    logic [c3cf_pkg::WREG_W-1:0] kernel_cols [3];
    c3cf_pkg::pixel_t            line_mem [2*LINE_LEN];
    c3cf_pkg::pcol_t             win [3];
    int unsigned                 col_pos;
    int unsigned                 row_pos;
    longint unsigned             outs_in_frame;

    c3cf_pkg::result_t expected_results [$];
    pix_item_t         pending_items [$];

    int errors        = 0;
    int send_idle_pct = 31;
    int recv_idle_pct = 48;
    int hold_seq      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int stall_cycles  = 0;
    int random_items  = 0;

    c3cf_in_if  pix ();
    c3cf_out_if flt ();

    assign pix.valid    = send_valid;
    assign pix.cmd      = send_cmd;
    assign pix.pixel_in = send_pixel;
    assign flt.ready    = take_ready;

    conv3x3_clamped_filter #(
        .MAX_WIDTH        (LINE_LEN),
        .WEIGHT_FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pix),
        .filtered  (flt)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void filter_step(c3cf_pkg::cmd_t kind, c3cf_pkg::pixel_t sample);
        int unsigned                      w, h, col, row, cc, cr;
        c3cf_pkg::pixel_t                 px, top, mid;
        c3cf_pkg::pcol_t                  view [3];
        logic                             emit;
        logic signed [c3cf_pkg::WT_W-1:0] wt;
        longint                           acc;
        longint unsigned                  scaled, area;
        c3cf_pkg::result_t                res;
        w = geo_width;
        if (w == 0) w = 1;
        if (w > LINE_LEN) w = LINE_LEN;
        h = geo_height;
        if (h == 0) h = 1;
        col = col_pos;
        row = row_pos;
        if (col >= LINE_LEN) col = 0;
        px = (kind == c3cf_pkg::CMD_DRAIN) ? '0 : sample;
        if (kind == c3cf_pkg::CMD_DRAIN && row == 0 && col == 0)
            return;
        top = line_mem[col];
        mid = line_mem[LINE_LEN + col];
        cc = 0;
        cr = 0;
        if (col == 0)
        begin
            view[0] = win[1];
            view[1] = win[2];
            view[2] = '0;
            cc = w - 1;
            cr = row - 2;
        end
        win[0] = win[1];
        win[1] = win[2];
        win[2][0] = top;
        win[2][1] = mid;
        win[2][2] = px;
        if (col != 0)
        begin
            for (int k = 0; k < 3; k++)
                view[k] = win[k];
            cc = col - 1;
            cr = row - 1;
        end
        line_mem[col] = mid;
        line_mem[LINE_LEN + col] = px;
        emit = (row >= 2) || (row == 1 && col >= 1);
        if (col + 1 >= w)
        begin
            col_pos = 0;
            row_pos = row + 1;
        end
        else
            col_pos = col + 1;
        if (!emit)
            return;
        acc = 0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                if (!(i == 0 && cc == 0) && !(i == 2 && cc + 1 >= w) &&
                    !(j == 0 && cr == 0) && !(j == 2 && cr + 1 >= h))
                begin
                    wt = kernel_cols[i][16*j +: 16];
                    acc += longint'(view[i][j]) * longint'(wt);
                end
        if (acc <= 0)
            res.pixel = '0;
        else
        begin
            scaled = longint'(acc) >> FRAC_BITS;
            res.pixel = (scaled > 255) ? c3cf_pkg::PIX_MAX : c3cf_pkg::pixel_t'(scaled);
        end
        area = w;
        area = area * h;
        if (outs_in_frame + 1 >= area)
        begin
            res.frame_end = 1'b1;
            col_pos = 0;
            row_pos = 0;
            outs_in_frame = 0;
        end
        else
        begin
            res.frame_end = 1'b0;
            outs_in_frame++;
        end
        expected_results.push_back(res);
    endfunction

    function automatic logic [c3cf_pkg::WREG_W-1:0] random_kernel_col();
        logic [c3cf_pkg::WREG_W-1:0] word;
        int unsigned                 pick;
        for (int k = 0; k < 3; k++)
        begin
            pick = $urandom_range(9);
            if (pick < 5)
                word[16*k +: 16] = 16'(int'($urandom_range(900)) - 300);
            else if (pick < 8)
                word[16*k +: 16] = 16'($urandom);
            else
                word[16*k +: 16] = '0;
        end
        return word;
    endfunction

    task automatic write_reg(c3cf_pkg::cfg_reg_t idx, logic [c3cf_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            c3cf_pkg::REG_FRAME_WIDTH:    geo_width      = value[c3cf_pkg::FW_W-1:0];
            c3cf_pkg::REG_FRAME_HEIGHT:   geo_height     = value[c3cf_pkg::FH_W-1:0];
            c3cf_pkg::REG_WEIGHTS_FIRST:  kernel_cols[0] = value[c3cf_pkg::WREG_W-1:0];
            c3cf_pkg::REG_WEIGHTS_MIDDLE: kernel_cols[1] = value[c3cf_pkg::WREG_W-1:0];
            c3cf_pkg::REG_WEIGHTS_LAST:   kernel_cols[2] = value[c3cf_pkg::WREG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(int unsigned w, int unsigned h);
        logic [c3cf_pkg::CFG_DATA_W-1:0] word;
        word = c3cf_pkg::CFG_DATA_W'({$urandom, $urandom});
        word[c3cf_pkg::FW_W-1:0] = c3cf_pkg::FW_W'(w);
        write_reg(c3cf_pkg::REG_FRAME_WIDTH, word);
        word = c3cf_pkg::CFG_DATA_W'({$urandom, $urandom});
        word[c3cf_pkg::FH_W-1:0] = c3cf_pkg::FH_W'(h);
        write_reg(c3cf_pkg::REG_FRAME_HEIGHT, word);
    endtask

    task automatic set_kernel(logic [c3cf_pkg::WREG_W-1:0] first,
                              logic [c3cf_pkg::WREG_W-1:0] middle,
                              logic [c3cf_pkg::WREG_W-1:0] last);
        write_reg(c3cf_pkg::REG_WEIGHTS_FIRST, first);
        write_reg(c3cf_pkg::REG_WEIGHTS_MIDDLE, middle);
        write_reg(c3cf_pkg::REG_WEIGHTS_LAST, last);
    endtask

    task automatic push_item(c3cf_pkg::cmd_t kind, c3cf_pkg::pixel_t value);
        pix_item_t item;
        item.kind  = kind;
        item.value = value;
        pending_items.push_back(item);
    endtask

    task automatic push_frame(int unsigned w, int unsigned h, int unsigned flush,
                              int unsigned noise_pct);
        for (int unsigned k = 0; k < w * h; k++)
            if ($urandom_range(99) < noise_pct)
                push_item(c3cf_pkg::CMD_DRAIN, 8'($urandom));
            else
                push_item(c3cf_pkg::CMD_PIXEL, 8'($urandom));
        for (int unsigned k = 0; k < flush; k++)
            if ($urandom_range(9) < 7)
                push_item(c3cf_pkg::CMD_DRAIN, 8'($urandom));
            else
                push_item(c3cf_pkg::CMD_PIXEL, 8'($urandom));
        random_items += w * h + flush;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || send_valid || expected_results.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : drive_pixels
        pix_item_t next_item;
        if (rst_n)
        begin
            if (send_valid && pix.ready)
                filter_step(send_cmd, send_pixel);
            if (!send_valid || pix.ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_item = pending_items.pop_front();
                    send_valid <= 1'b1;
                    send_cmd   <= next_item.kind;
                    send_pixel <= next_item.value;
                end
                else
                    send_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        c3cf_pkg::result_t want;
        if (rst_n)
        begin
            if (flt.valid && take_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with none expected: pixel_out %0d frame_end %0b",
                             $time, flt.pixel_out, flt.frame_end);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (flt.pixel_out !== want.pixel)
                    begin
                        errors++;
                        $display("%0t: pixel_out mismatch: expected %0d actual %0d",
                                 $time, want.pixel, flt.pixel_out);
                    end
                    if (flt.frame_end !== want.frame_end)
                    begin
                        errors++;
                        $display("%0t: frame_end mismatch: expected %0b actual %0b",
                                 $time, want.frame_end, flt.frame_end);
                    end
                end
            end
            // Hold ready low for a long stretch so the block backs up.
            if (hold_seq != hold_seen)
            begin
                hold_seen  <= hold_seq;
                hold_left  <= HOLD_CYCLES;
                take_ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left  <= hold_left - 1;
                take_ready <= 1'b0;
            end
            else
                take_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (send_valid && pix.ready) || (flt.valid && take_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : stimulus
        int unsigned fw, fh, fw_eff, fh_eff, flush, pick, phase;
        geo_width      = c3cf_pkg::FW_RESET;
        geo_height     = c3cf_pkg::FH_RESET;
        kernel_cols[0] = c3cf_pkg::WREG_RESET_SIDE;
        kernel_cols[1] = c3cf_pkg::WREG_RESET_CENTER;
        kernel_cols[2] = c3cf_pkg::WREG_RESET_SIDE;
        for (int k = 0; k < 2 * LINE_LEN; k++)
            line_mem[k] = '0;
        for (int k = 0; k < 3; k++)
            win[k] = '0;
        col_pos       = 0;
        row_pos       = 0;
        outs_in_frame = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Oversized width first, then narrow the row mid-frame so the column wraps at once.
        set_geometry(2047, 1);
        for (int k = 0; k < 20; k++)
            push_item(c3cf_pkg::CMD_PIXEL, 8'($urandom));
        wait_idle();
        set_geometry(4, 1);
        for (int k = 0; k < 5; k++)
            push_item(c3cf_pkg::CMD_PIXEL, 8'($urandom));
        wait_idle();

        push_item(c3cf_pkg::CMD_DRAIN, 8'hA5);
        wait_idle();
        set_kernel({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
        set_geometry(2, 2);
        push_item(c3cf_pkg::CMD_PIXEL, 8'hFF);
        push_item(c3cf_pkg::CMD_DRAIN, 8'h5A);
        push_item(c3cf_pkg::CMD_PIXEL, 8'hFF);
        push_item(c3cf_pkg::CMD_PIXEL, 8'h00);
        push_item(c3cf_pkg::CMD_DRAIN, 8'h00);
        push_item(c3cf_pkg::CMD_PIXEL, 8'hFF);
        push_item(c3cf_pkg::CMD_DRAIN, 8'hFF);
        wait_idle();

        set_kernel({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
        set_geometry(1, 2);
        push_item(c3cf_pkg::CMD_PIXEL, 8'hFF);
        push_item(c3cf_pkg::CMD_PIXEL, 8'hFF);
        push_item(c3cf_pkg::CMD_DRAIN, 8'h00);
        push_item(c3cf_pkg::CMD_DRAIN, 8'h00);
        wait_idle();

        set_kernel(c3cf_pkg::WREG_RESET_SIDE, c3cf_pkg::WREG_RESET_CENTER,
                   c3cf_pkg::WREG_RESET_SIDE);
        set_geometry(0, 0);
        push_item(c3cf_pkg::CMD_PIXEL, 8'd200);
        push_item(c3cf_pkg::CMD_DRAIN, 8'h00);
        push_item(c3cf_pkg::CMD_PIXEL, 8'd77);
        wait_idle();

        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            if (random_items < RANDOM_ITEMS / 3)
            begin
                send_idle_pct <= 31;
                recv_idle_pct <= 48;
            end
            else if (random_items < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct <= 48;
                recv_idle_pct <= 31;
            end
            else
            begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end
            pick = $urandom_range(9);
            if (pick < 7)
                fw = $urandom_range(8, 1);
            else if (pick < 9)
                fw = $urandom_range(40, 9);
            else
                fw = $urandom_range(3);
            fh = ($urandom_range(9) == 0) ? 0 : $urandom_range(6, 1);
            if (phase == 2 || phase == 12)
            begin
                fw = 30;
                fh = 4;
            end
            set_geometry(fw, fh);
            if ($urandom_range(2) != 0)
                write_reg(c3cf_pkg::REG_WEIGHTS_FIRST, random_kernel_col());
            if ($urandom_range(2) != 0)
                write_reg(c3cf_pkg::REG_WEIGHTS_MIDDLE, random_kernel_col());
            if ($urandom_range(2) != 0)
                write_reg(c3cf_pkg::REG_WEIGHTS_LAST, random_kernel_col());
            @(posedge clk);
            if (phase == 2 || phase == 12)
                hold_seq <= hold_seq + 1;
            if ($urandom_range(3) == 0)
                push_item(c3cf_pkg::CMD_DRAIN, 8'($urandom));
            fw_eff = (fw == 0) ? 1 : fw;
            fh_eff = (fh == 0) ? 1 : fh;
            flush = ($urandom_range(6) == 0) ? $urandom_range(fw_eff) : fw_eff + 1;
            push_frame(fw_eff, fh_eff, flush, 10);
            wait_idle();
            phase++;
        end

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
